/* sv/kole_pkg.sv */
// package for the keyed ordered list engine
// operation and status codes, default sizes; no dependencies
package kole_pkg;
	localparam int CAPACITY_DEF = 16;
	localparam logic [2:0] FN_PREPEND = 3'd0;
	localparam logic [2:0] FN_APPEND  = 3'd1;
	localparam logic [2:0] FN_POP     = 3'd2;
	localparam logic [2:0] FN_FIND    = 3'd3;
	localparam logic [2:0] FN_REMOVE  = 3'd4;
	localparam logic [2:0] FN_CLEAR   = 3'd5;
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
endpackage

/* sv/kole_slot_mem.sv */
// slot store: key, value and link per slot, one write and one registered read port
// depends on nothing but its parameter
module kole_slot_mem #(
	parameter int CAPACITY = 16,
	localparam int AW = $clog2(CAPACITY)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_key,
	output logic [31:0]   rd_value,
	output logic [AW-1:0] rd_link,
	input  logic          wr_en,
	input  logic          wr_kv,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_key,
	input  logic [31:0]   wr_value,
	input  logic [AW-1:0] wr_link
);
	logic [31:0]   key_mem [CAPACITY];
	logic [31:0]   val_mem [CAPACITY];
	logic [AW-1:0] lnk_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lnk_mem[wr_addr] <= wr_link;
			if (wr_kv) begin
				key_mem[wr_addr] <= wr_key;
				val_mem[wr_addr] <= wr_value;
			end
		end
		if (rd_en) begin
			rd_key   <= key_mem[rd_addr];
			rd_value <= val_mem[rd_addr];
			rd_link  <= lnk_mem[rd_addr];
		end
	end
endmodule

/* sv/keyed_ordered_list_engine_unit.sv */
// Keyed ordered list engine. One operation is taken at a time. Prepend, clear, unused codes,
// refused inserts and operations on an empty list go from execute to output; append and pop
// pass a wait state first; find and remove walk from the head, up to count entries, via the
// single read port of the slot memory, which yields one link per cycle. A stalled result waits
// in the output register; the next item is accepted from the cycle after it is taken. Slot
// memory holds key, value and link; head, tail, count and free map are flip-flops.
module keyed_ordered_list_engine_unit #(
	parameter int CAPACITY = kole_pkg::CAPACITY_DEF,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [31:0] key,
	input  logic [31:0] data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] data_out,
	output logic [4:0]  count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);
	import kole_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]    state_q;
	logic [2:0]    func_q;
	logic [31:0]   key_q, data_q;
	logic [AW-1:0] head_q, tail_q, cur_q, prev_q;
	logic [CW-1:0] cnt_q, steps_q;
	logic [CAPACITY-1:0] free_q;
	logic [4:0]    max_q;
	logic [1:0]    status_q;
	logic [31:0]   dout_q;

	logic          rd_en, wr_en, wr_kv;
	logic [AW-1:0] rd_addr, wr_addr, wr_link;
	logic [31:0]   rd_key, rd_value;
	logic [AW-1:0] rd_link;

	logic [AW-1:0] free_idx;
	logic          full;

	always_comb begin
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--)
			if (free_q[i]) free_idx = AW'(i);
	end

	assign full = (cnt_q == CW'(CAPACITY)) ||
		(max_q != 5'd0 && 32'(cnt_q) >= 32'(max_q));

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = (state_q == S_OUT);
	assign status    = status_q;
	assign data_out  = dout_q;
	assign count     = 5'(cnt_q);

	kole_slot_mem #(.CAPACITY(CAPACITY)) u_mem (
		.clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_key(rd_key),
		.rd_value(rd_value), .rd_link(rd_link), .wr_en(wr_en), .wr_kv(wr_kv),
		.wr_addr(wr_addr), .wr_key(key_q), .wr_value(data_q), .wr_link(wr_link)
	);

	// memory control
	always_comb begin
		rd_en = 1'b0;
		rd_addr = cur_q;
		wr_en = 1'b0;
		wr_kv = 1'b0;
		wr_addr = free_idx;
		wr_link = head_q;
		if (state_q == S_EXEC) begin
			if (func_q == FN_POP || func_q == FN_FIND || func_q == FN_REMOVE) begin
				rd_en = (cnt_q != '0);
				rd_addr = head_q;
			end else if ((func_q == FN_PREPEND || func_q == FN_APPEND) && !full) begin
				wr_en = 1'b1;
				wr_kv = 1'b1;
			end
		end else if (state_q == S_WALK) begin
			if (rd_key != key_q && steps_q + 1'b1 < cnt_q) begin
				rd_en = 1'b1;
				rd_addr = rd_link;
			end
		end
		// tail link is fixed in a second write, see the sequencer
		if (state_q == S_WAIT && func_q == FN_APPEND) begin
			wr_en = (cnt_q != CW'(1));
			wr_addr = prev_q;
			wr_link = tail_q;
		end
		if (state_q == S_WALK && func_q == FN_REMOVE && rd_key == key_q &&
				steps_q != '0) begin
			wr_en = 1'b1;
			wr_addr = prev_q;
			wr_link = rd_link;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
			free_q <= '1;
			max_q <= '0;
			func_q <= '0;
			key_q <= '0;
			data_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			steps_q <= '0;
			status_q <= '0;
			dout_q <= '0;
		end else begin
			if (cfg_valid) max_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						key_q <= key;
						data_q <= data;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= ST_OK;
					dout_q <= '0;
					state_q <= S_OUT;
					cur_q <= head_q;
					prev_q <= head_q;
					steps_q <= '0;
					if (func_q == FN_PREPEND || func_q == FN_APPEND) begin
						if (full) begin
							status_q <= ST_FULL;
						end else begin
							free_q[free_idx] <= 1'b0;
							cnt_q <= cnt_q + 1'b1;
							dout_q <= data_q;
							if (func_q == FN_PREPEND) begin
								head_q <= free_idx;
								if (cnt_q == '0) tail_q <= free_idx;
							end else begin
								if (cnt_q == '0) head_q <= free_idx;
								prev_q <= tail_q;
								tail_q <= free_idx;
								state_q <= S_WAIT;
							end
						end
					end else if (func_q == FN_POP || func_q == FN_FIND ||
							func_q == FN_REMOVE) begin
						if (cnt_q == '0) status_q <= ST_NOTFOUND;
						else state_q <= (func_q == FN_POP) ? S_WAIT : S_WALK;
					end else if (func_q == FN_CLEAR) begin
						free_q <= '1;
						head_q <= '0;
						tail_q <= '0;
						cnt_q <= '0;
					end
				end
				S_WAIT: begin
					// append link write, or pop read data ready
					state_q <= S_OUT;
					if (func_q == FN_POP) begin
						dout_q <= rd_value;
						free_q[head_q] <= 1'b1;
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == CW'(1)) begin
							head_q <= '0;
							tail_q <= '0;
						end else begin
							head_q <= rd_link;
						end
					end
				end
				S_WALK: begin
					if (rd_key == key_q) begin
						state_q <= S_OUT;
						dout_q <= rd_value;
						if (func_q == FN_REMOVE) begin
							free_q[cur_q] <= 1'b1;
							cnt_q <= cnt_q - 1'b1;
							if (cnt_q == CW'(1)) begin
								head_q <= '0;
								tail_q <= '0;
							end else if (steps_q == '0) begin
								head_q <= rd_link;
							end else if (cur_q == tail_q) begin
								tail_q <= prev_q;
							end
						end
					end else if (steps_q + 1'b1 < cnt_q) begin
						prev_q <= cur_q;
						cur_q <= rd_link;
						steps_q <= steps_q + 1'b1;
					end else begin
						status_q <= ST_NOTFOUND;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
